[design/wocf_pkg.sv]
// ----------------------------------------------------------------------------
// wocf_pkg: shared types and constants of the outlier clamp filter
// Sample type, register map, opcodes, control state and the control
// bundles that go from the sequencer to the cells and to the ranker.
// ----------------------------------------------------------------------------
package wocf_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned WsW          = 5;
  localparam int unsigned AddrW        = 3;
  localparam int unsigned ApbW         = 32;
  localparam int unsigned MaxWindowDef = 16;
  localparam int unsigned MinWindow    = 3;

  localparam logic [WsW-1:0] WsReset = 5'd8;

  typedef logic signed [DataW-1:0] sample_t;

  localparam sample_t SampleMin = {1'b1, {(DataW-1){1'b0}}};
  localparam sample_t SampleMax = {1'b0, {(DataW-1){1'b1}}};

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_WINDOW_SIZE = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_FILTER  = 1'b0,
    OP_RESTART = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } rank_ctrl_t;

endpackage

[design/wocf_if.sv]
// ----------------------------------------------------------------------------
// wocf_if: stream channels of the outlier clamp filter
// Input channel carries opcode and sample, output channel carries the
// filtered word and the warming flag; both use valid/ready.
// ----------------------------------------------------------------------------
interface wocf_in_if;
  import wocf_pkg::*;

  logic    valid;
  logic    ready;
  logic    opcode;
  sample_t sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface wocf_out_if;
  import wocf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    warming;

  modport source (output valid, output filtered, output warming, input ready);
  modport sink   (input valid, input filtered, input warming, output ready);
endinterface

[design/window_outlier_clamp_filter.sv]
// ----------------------------------------------------------------------------
// window_outlier_clamp_filter: sliding-window order-statistic clamp filter
// Keeps the last N samples in a chain of cells, ranks them by rotating the
// chain past a tracker, and, once the window is full, clamps each new
// sample to the second largest and second smallest of the window.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+---------------------------
//  in_i    | in  | valid / ready   | opcode, sample
//  out_o   | out | valid / ready   | filtered, warming
//  apb     | in  | psel / penable  | paddr, pwdata, prdata
//
//  A filtered word goes through accept, a rotation of the cell chain
//  through the ranker (one entry per cycle), and the clamp cycle.
//  Fill and restart words skip the rotation. One word is in flight at a time.
//  The output register holds a result while the next word is accepted;
//  the clamp cycle waits until that register is free.
//  Reset clears the fill count and sets the window size to 8; the cells
//  hold no reset and are read only after being written.
// ----------------------------------------------------------------------------
module window_outlier_clamp_filter #(
  parameter int unsigned MaxWindow = wocf_pkg::MaxWindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wocf_pkg::AddrW-1:0]  paddr,
  input  logic [wocf_pkg::ApbW-1:0]   pwdata,
  output logic [wocf_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  wocf_in_if.sink                     in_i,
  wocf_out_if.source                  out_o
);
  import wocf_pkg::*;

  localparam int unsigned NW = $clog2(MaxWindow + 1);
  localparam int unsigned CW = (NW > WsW) ? NW : WsW;

  state_e state_q, state_d;

  logic [WsW-1:0] ws_q, ws_d;
  logic [NW-1:0]  fill_cnt_q, fill_cnt_d;
  logic [NW-1:0]  scan_cnt_q, scan_cnt_d;
  logic [NW-1:0]  n_eff;
  logic [CW-1:0]  ws_ext;

  logic    restart_q, filter_q;
  sample_t sample_q;

  logic    out_valid_q;
  sample_t out_data_q;
  logic    out_warm_q;

  logic       accept, cfg_wr, out_free, commit;
  sample_t    tail_data, result, hi2, lo2;
  cell_ctrl_t shift_ctrl;
  rank_ctrl_t rank_ctrl;
  sample_t    cell_data [MaxWindow];

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? ApbW'(ws_q) : '0;
  assign ws_d   = cfg_wr ? pwdata[WsW-1:0] : ws_q;

  // saturate the window size to MinWindow..MaxWindow
  assign ws_ext = CW'(ws_q);
  always_comb begin
    if (ws_ext < CW'(MinWindow)) begin
      n_eff = NW'(MinWindow);
    end else if (ws_ext > CW'(MaxWindow)) begin
      n_eff = NW'(MaxWindow);
    end else begin
      n_eff = NW'(ws_ext);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign commit     = (state_q == ST_EMIT) && out_free;

  // clamp against the ranked window
  always_comb begin
    if (!filter_q) begin
      result = sample_q;
    end else if (sample_q > hi2) begin
      result = hi2;
    end else if (sample_q < lo2) begin
      result = lo2;
    end else begin
      result = sample_q;
    end
  end

  always_comb begin
    state_d          = state_q;
    scan_cnt_d       = scan_cnt_q;
    fill_cnt_d       = fill_cnt_q;
    shift_ctrl.shift = 1'b0;
    shift_ctrl.load  = 1'b0;
    rank_ctrl.clear  = accept;
    rank_ctrl.step   = 1'b0;
    tail_data        = cell_data[0];
    unique case (state_q)
      ST_IDLE: begin
        scan_cnt_d = '0;
        if (accept) begin
          state_d = (in_i.opcode == OP_FILTER && fill_cnt_q >= n_eff) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        // rotate the window once around, head word into the ranker
        shift_ctrl.shift = 1'b1;
        rank_ctrl.step   = 1'b1;
        scan_cnt_d       = scan_cnt_q + 1'b1;
        if (scan_cnt_q == n_eff - 1'b1) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        tail_data = sample_q;
        if (commit) begin
          state_d = ST_IDLE;
          if (restart_q) begin
            fill_cnt_d = '0;
          end else if (filter_q) begin
            // drop the oldest, append the raw sample
            shift_ctrl.shift = 1'b1;
          end else begin
            shift_ctrl.load = 1'b1;
            fill_cnt_d      = fill_cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_wr) begin
      fill_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ws_q       <= WsReset;
      fill_cnt_q <= '0;
      scan_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      ws_q       <= ws_d;
      fill_cnt_q <= fill_cnt_d;
      scan_cnt_q <= scan_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      restart_q <= (in_i.opcode == OP_RESTART);
      filter_q  <= (in_i.opcode == OP_FILTER) && (fill_cnt_q >= n_eff);
      sample_q  <= in_i.sample;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= result;
      out_warm_q <= !filter_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_data_q;
  assign out_o.warming  = out_warm_q;

  // cell chain: entry 0 is the oldest, entry n-1 takes the tail word
  for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
    cell_ctrl_t ctrl;
    sample_t    shift_in;

    always_comb begin
      ctrl.shift = shift_ctrl.shift;
      ctrl.load  = shift_ctrl.load && (fill_cnt_q == NW'(i));
    end

    if (i == MaxWindow - 1) begin : g_last
      assign shift_in = tail_data;
    end else begin : g_mid
      assign shift_in = (n_eff == NW'(i + 1)) ? tail_data : cell_data[i+1];
    end

    wocf_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .shift_in_i  (shift_in),
      .load_data_i (sample_q),
      .data_o      (cell_data[i])
    );
  end

  wocf_rank u_rank (
    .clk_i  (clk_i),
    .ctrl_i (rank_ctrl),
    .data_i (cell_data[0]),
    .hi2_o  (hi2),
    .lo2_o  (lo2)
  );

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q <= n_eff)
    else $error("fill count beyond window size");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_cnt_q < n_eff))
    else $error("scan counter beyond window size");

  a_out_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result word raised outside the clamp cycle");

  a_rank_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && filter_q) |-> (lo2 <= hi2))
    else $error("ranked bounds out of order");

endmodule

[design/wocf_cell.sv]
// ----------------------------------------------------------------------------
// wocf_cell: one window entry
// Holds one stored sample; loads a new sample during fill or takes the
// word of its neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module wocf_cell (
  input  logic                 clk_i,
  input  wocf_pkg::cell_ctrl_t ctrl_i,
  input  wocf_pkg::sample_t    shift_in_i,
  input  wocf_pkg::sample_t    load_data_i,
  output wocf_pkg::sample_t    data_o
);
  import wocf_pkg::*;

  sample_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[design/wocf_rank.sv]
// ----------------------------------------------------------------------------
// wocf_rank: running two-largest / two-smallest tracker
// Takes one word per cycle from the head of the chain while stepped, and keeps the
// second largest and second smallest seen since the last clear.
// ----------------------------------------------------------------------------
module wocf_rank (
  input  logic                 clk_i,
  input  wocf_pkg::rank_ctrl_t ctrl_i,
  input  wocf_pkg::sample_t    data_i,
  output wocf_pkg::sample_t    hi2_o,
  output wocf_pkg::sample_t    lo2_o
);
  import wocf_pkg::*;

  sample_t hi1_q, hi2_q, lo1_q, lo2_q;
  sample_t hi1_d, hi2_d, lo1_d, lo2_d;

  always_comb begin
    hi1_d = hi1_q;
    hi2_d = hi2_q;
    lo1_d = lo1_q;
    lo2_d = lo2_q;
    if (ctrl_i.clear) begin
      // sentinels: the first two words then settle the pairs exactly
      hi1_d = SampleMin;
      hi2_d = SampleMin;
      lo1_d = SampleMax;
      lo2_d = SampleMax;
    end else if (ctrl_i.step) begin
      if (data_i > hi1_q) begin
        hi2_d = hi1_q;
        hi1_d = data_i;
      end else if (data_i > hi2_q) begin
        hi2_d = data_i;
      end
      if (data_i < lo1_q) begin
        lo2_d = lo1_q;
        lo1_d = data_i;
      end else if (data_i < lo2_q) begin
        lo2_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hi1_q <= hi1_d;
    hi2_q <= hi2_d;
    lo1_q <= lo1_d;
    lo2_q <= lo2_d;
  end

  assign hi2_o = hi2_q;
  assign lo2_o = lo2_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the window outlier clamp filter
// Runs a short table of directed words, then random words over a series of
// window sizes. Every result is checked against the expected word of the table
// or a local model of the window and its clamp. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import wocf_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = MaxWindowDef + 8;
  localparam int unsigned PhaseWords  = 170;

  typedef struct packed {
    sample_t filtered;
    logic    warming;
  } out_word_t;

  typedef struct {
    opcode_e   op;
    sample_t   smp;
    bit        typed;
    out_word_t word;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [ApbW-1:0]      pwdata;
  logic [ApbW-1:0]      prdata;
  logic                 pready;

  wocf_in_if  in_if ();
  wocf_out_if out_if ();

  window_outlier_clamp_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // model of the window
  logic [WsW-1:0] ws_reg;
  sample_t        win_hist [MaxWindowDef];
  int unsigned    fill_cnt;

  out_word_t   pending_q [$];
  dir_row_t    dir_tab [$];
  int unsigned err_cnt;
  int unsigned words_seen;
  int unsigned cyc_cnt;
  int unsigned burst_left;
  bit          no_gaps;

  always #6 clk_i = ~clk_i;

  function automatic out_word_t clamp_predict(opcode_e op, sample_t s);
    out_word_t   r;
    int unsigned n;
    sample_t     hi1;
    sample_t     hi2;
    sample_t     lo1;
    sample_t     lo2;
    sample_t     v;
    r.filtered = s;
    r.warming  = 1'b1;
    n = (ws_reg < MinWindow) ? MinWindow : ((ws_reg > MaxWindowDef) ? MaxWindowDef : ws_reg);
    if (op == OP_RESTART) begin
      fill_cnt = 0;
    end else if (fill_cnt < n) begin
      win_hist[fill_cnt] = s;
      fill_cnt++;
    end else begin
      // track the two largest and two smallest; duplicates rank separately
      hi1 = (win_hist[0] > win_hist[1]) ? win_hist[0] : win_hist[1];
      hi2 = (win_hist[0] > win_hist[1]) ? win_hist[1] : win_hist[0];
      lo1 = hi2;
      lo2 = hi1;
      for (int i = 2; i < n; i++) begin
        v = win_hist[i];
        if (v > hi1) begin
          hi2 = hi1;
          hi1 = v;
        end else if (v > hi2) begin
          hi2 = v;
        end
        if (v < lo1) begin
          lo2 = lo1;
          lo1 = v;
        end else if (v < lo2) begin
          lo2 = v;
        end
      end
      if (s > hi2) r.filtered = hi2;
      else if (s < lo2) r.filtered = lo2;
      r.warming = 1'b0;
      for (int i = 0; i + 1 < n; i++) win_hist[i] = win_hist[i + 1];
      win_hist[n - 1] = s;
    end
    return r;
  endfunction

  function automatic void add_row(opcode_e op, sample_t smp, bit typed, sample_t f, logic w);
    dir_row_t row;
    row.op            = op;
    row.smp           = smp;
    row.typed         = typed;
    row.word.filtered = f;
    row.word.warming  = w;
    dir_tab.push_back(row);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0:       s = SampleMax;
      1:       s = SampleMin;
      2, 3:    s = sample_t'($urandom_range(0, 16)) - 8;
      4, 5:    s = sample_t'($urandom_range(0, 2000)) - 1000;
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [ApbW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW_SIZE) begin
      ws_reg   = data[WsW-1:0];
      fill_cnt = 0;
    end
  endtask

  task automatic apb_check_ws();
    logic [ApbW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({REG_WINDOW_SIZE, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== ApbW'(ws_reg)) begin
      $display("%0t: window_size readback expected %0d got %0d", $time, ws_reg, got);
      err_cnt++;
    end
  endtask

  // offer one word in bursts with random gaps; predict once it is taken
  task automatic send_word(opcode_e op, sample_t smp, bit typed, out_word_t typed_word);
    int unsigned gap;
    out_word_t   w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.sample <= smp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    w = clamp_predict(op, smp);
    pending_q.push_back(typed ? typed_word : w);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word filtered %0d warming %0b", $time,
                 out_if.filtered, out_if.warming);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (e.filtered !== out_if.filtered) begin
          $display("%0t: filtered expected %0d got %0d", $time, e.filtered, out_if.filtered);
          err_cnt++;
        end
        if (e.warming !== out_if.warming) begin
          $display("%0t: warming expected %0b got %0b", $time, e.warming, out_if.warming);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: changing stall modes, plus one long hold-off to back up the input
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    out_if.ready = 1'b0;
    mode_left    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_seen >= 400) begin
        hold_left = 250;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= $urandom_range(0, 1);
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    int        ws_plan [11];
    out_word_t none;
    opcode_e   op;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.opcode = OP_FILTER;
    in_if.sample = '0;
    err_cnt      = 0;
    words_seen   = 0;
    cyc_cnt      = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    ws_reg       = WsReset;
    fill_cnt     = 0;
    none         = '0;

    // fill with extremes and duplicates, clamp, restart, refill with equal values
    add_row(OP_FILTER,  SampleMax,    1, SampleMax,    1'b1);
    add_row(OP_FILTER,  SampleMin,    1, SampleMin,    1'b1);
    add_row(OP_FILTER,  0,            1, 0,            1'b1);
    add_row(OP_FILTER,  -1,           1, -1,           1'b1);
    add_row(OP_FILTER,  5,            1, 5,            1'b1);
    add_row(OP_FILTER,  5,            1, 5,            1'b1);
    add_row(OP_FILTER,  100,          1, 100,          1'b1);
    add_row(OP_FILTER,  -100,         1, -100,         1'b1);
    add_row(OP_FILTER,  SampleMax,    0, 0,            1'b0);
    add_row(OP_FILTER,  SampleMin,    0, 0,            1'b0);
    add_row(OP_FILTER,  3,            0, 0,            1'b0);
    add_row(OP_FILTER,  5,            0, 0,            1'b0);
    add_row(OP_RESTART, 32'h12345678, 1, 32'h12345678, 1'b1);
    add_row(OP_RESTART, SampleMin,    1, SampleMin,    1'b1);
    for (int i = 0; i < 8; i++) add_row(OP_FILTER, 7, 1, 7, 1'b1);
    add_row(OP_FILTER,  SampleMax,    0, 0,            1'b0);
    add_row(OP_FILTER,  SampleMin,    0, 0,            1'b0);
    add_row(OP_FILTER,  7,            0, 0,            1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check_ws();

    foreach (dir_tab[i]) send_word(dir_tab[i].op, dir_tab[i].smp, dir_tab[i].typed,
                                   dir_tab[i].word);
    in_if.valid <= 1'b0;

    // -1: write the unused index, which must leave the full window in place
    ws_plan = '{-1, 3, 16, 0, 31, 2, 17, 5, 12, -2, -2};
    foreach (ws_plan[p]) begin
      wait_idle();
      if (ws_plan[p] == -1) begin
        apb_write(REG_NONE, 32'd3);
      end else begin
        apb_write(REG_WINDOW_SIZE, (ws_plan[p] == -2) ? $urandom_range(0, 31) : ws_plan[p]);
        @(posedge clk_i);
        apb_check_ws();
      end
      no_gaps    = (p % 3 == 1);
      burst_left = 0;
      for (int k = 0; k < PhaseWords; k++) begin
        op = ($urandom_range(0, 39) == 0) ? OP_RESTART : OP_FILTER;
        send_word(op, rand_sample(), 1'b0, none);
      end
      in_if.valid <= 1'b0;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/wocf_pkg.sv
design/wocf_if.sv
design/wocf_cell.sv
design/wocf_rank.sv
design/window_outlier_clamp_filter.sv
tb/tb_top.sv
